FILE: rtl/gapg_pkg.sv
// Shared types, constants and the sine lookup table of the gradient arrow pattern generator.
package gapg_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int FRAC_W      = 16;
    localparam int NX_W        = FRAC_W + 1;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = FRAC_W / DIV_STEPS;
    localparam int NSTAGE      = 7;

    // The table depth is a power of two, so the table index is the top bits of the phase.
    localparam int SINE_DEPTH  = 256;
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);

    localparam logic [NX_W-1:0] ONE_Q16  = NX_W'(65536);
    localparam logic [NX_W-1:0] HALF_Q16 = NX_W'(32768);
    localparam logic [7:0]      ALPHA    = 8'hFF;
    localparam logic [7:0]      CH_FULL  = 8'hFF;

    // Multiply by 2731 and shift right by 13 gives floor(s / 3) for every s up to 2048.
    localparam logic [COORD_W-1:0] THIRD_MUL   = COORD_W'(2731);
    localparam int                 THIRD_SHIFT = 13;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
    localparam logic [31:0]      RESET_STEP   = 32'd410139165;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PHASE_STEP   = 2'd2
    } reg_idx_t;

    // Frame geometry taken straight from the dimension registers.
    typedef struct packed {
        logic               narrow;
        logic [COORD_W-1:0] d;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] s;
    } geom_a_t;

    // Arrow outline derived from the first geometry set.
    typedef struct packed {
        logic               hl_nz;
        logic [9:0]         hl;
        logic [10:0]        hl2;
        logic [8:0]         sw;
        logic [10:0]        hw;
        logic [COORD_W-1:0] s0;
        logic [COORD_W-1:0] s1;
        logic [COORD_W-1:0] s1e;
    } geom_b_t;

    typedef logic [SINE_DEPTH-1:0][NX_W-1:0] sine_tab_t;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // Sine of an angle in the first quadrant, angle and result in Q30, Taylor series.
    function automatic longint sin_q30(input longint unsigned xq);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (xq * xq) >> 30;
        term = xq;
        sum  = longint'(xq);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > ONE_Q30)
        begin
            sum = ONE_Q30;
        end
        return sum;
    endfunction

    // Entry k holds (sin(2*pi*k/depth) + 1) / 2 in Q1.16, rounded and saturated at one.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t       tab;
        longint unsigned q;
        longint unsigned r;
        longint unsigned m;
        longint          sv;
        longint          v;
        longint unsigned o;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            q  = (4 * longint'(k)) / SINE_DEPTH;
            r  = (4 * longint'(k)) % SINE_DEPTH;
            m  = q[0] ? SINE_DEPTH - r : r;
            sv = sin_q30((HALF_PI_Q30 * m) / SINE_DEPTH);
            v  = (q < 2) ? ONE_Q30 + sv : ONE_Q30 - sv;
            o  = (longint'(v) + 16384) >> 15;
            if (o > 65536)
            begin
                o = 65536;
            end
            tab[k] = NX_W'(o);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: rtl/gapg_div_stage.sv
// Four steps of the restoring divider that forms the normalized column position.
module gapg_div_stage (
    input  logic                               clk,
    input  logic                               en,
    input  logic [gapg_pkg::COORD_W-1:0]       d,
    input  logic [gapg_pkg::COORD_W-1:0]       r_in,
    input  logic [gapg_pkg::FRAC_W-1:0]        q_in,
    output logic [gapg_pkg::COORD_W-1:0]       r_reg,
    output logic [gapg_pkg::FRAC_W-1:0]        q_reg
);

    logic [gapg_pkg::COORD_W-1:0] r_next;
    logic [gapg_pkg::FRAC_W-1:0]  q_next;
    logic [gapg_pkg::COORD_W:0]   r2;

    // For a column below the divisor the remainder stays below it, so doubling it needs one extra bit only.
    always_comb
    begin
        r_next = r_in;
        q_next = q_in;
        r2     = '0;
        for (int i = 0; i < gapg_pkg::DIV_STEPS; i++)
        begin
            r2 = {r_next, 1'b0};
            if (r2 >= {1'b0, d})
            begin
                r_next = gapg_pkg::COORD_W'(r2 - {1'b0, d});
                q_next = {q_next[gapg_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                r_next = gapg_pkg::COORD_W'(r2);
                q_next = {q_next[gapg_pkg::FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/gapg_cfg.sv
// Register file on the APB-style port and the frame geometry derived from it.
module gapg_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic [31:0]          phase_step,
    output gapg_pkg::geom_a_t    geom_a_reg,
    output gapg_pkg::geom_b_t    geom_b_reg
);

    logic [gapg_pkg::DIM_W-1:0] width_reg;
    logic [gapg_pkg::DIM_W-1:0] width_next;
    logic [gapg_pkg::DIM_W-1:0] height_reg;
    logic [gapg_pkg::DIM_W-1:0] height_next;
    logic [31:0]                step_reg;
    logic [31:0]                step_next;
    logic                       wr;

    logic [gapg_pkg::DIM_W-1:0] w_sat;
    logic [gapg_pkg::DIM_W-1:0] h_sat;
    logic [gapg_pkg::DIM_W-1:0] wh_min;
    gapg_pkg::geom_a_t          geom_a_next;
    gapg_pkg::geom_b_t          geom_b_next;
    logic [23:0]                third_prod;
    logic [9:0]                 hl;
    logic [10:0]                half_s;
    logic [gapg_pkg::COORD_W-1:0] s1e;

    assign pready     = 1'b1;
    assign phase_step = step_reg;
    assign wr         = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        step_next   = step_reg;
        if (wr)
        begin
            case (paddr[3:2])
                gapg_pkg::REG_FRAME_WIDTH:  width_next  = pwdata[gapg_pkg::DIM_W-1:0];
                gapg_pkg::REG_FRAME_HEIGHT: height_next = pwdata[gapg_pkg::DIM_W-1:0];
                gapg_pkg::REG_PHASE_STEP:   step_next   = pwdata;
                default:                    step_next   = step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gapg_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_reg);
            gapg_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_reg);
            gapg_pkg::REG_PHASE_STEP:   prdata = step_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gapg_pkg::RESET_WIDTH;
            height_reg <= gapg_pkg::RESET_HEIGHT;
            step_reg   <= gapg_pkg::RESET_STEP;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            step_reg   <= step_next;
        end
    end

    // First geometry level: clamp the dimensions, take the halves, the divisor and the narrow flag.
    always_comb
    begin
        w_sat  = (width_reg > gapg_pkg::DIM_W'(gapg_pkg::MAX_DIM)) ?
                 gapg_pkg::DIM_W'(gapg_pkg::MAX_DIM) : width_reg;
        h_sat  = (height_reg > gapg_pkg::DIM_W'(gapg_pkg::MAX_DIM)) ?
                 gapg_pkg::DIM_W'(gapg_pkg::MAX_DIM) : height_reg;
        wh_min = (w_sat < h_sat) ? w_sat : h_sat;
        geom_a_next.narrow = (w_sat < gapg_pkg::DIM_W'(2));
        geom_a_next.d      = gapg_pkg::COORD_W'(w_sat - gapg_pkg::DIM_W'(1));
        geom_a_next.ax     = gapg_pkg::COORD_W'(w_sat >> 1);
        geom_a_next.ay     = gapg_pkg::COORD_W'(h_sat >> 1);
        geom_a_next.s      = gapg_pkg::COORD_W'(wh_min >> 1);
    end

    // Second level: head length, stem and head widths and the stem and head columns.
    assign third_prod = 24'(geom_a_reg.s) * 24'(gapg_pkg::THIRD_MUL);
    assign hl         = 10'(third_prod >> gapg_pkg::THIRD_SHIFT);
    assign half_s     = 11'(geom_a_reg.s >> 1);
    assign s1e        = gapg_pkg::COORD_W'(geom_a_reg.ax + gapg_pkg::COORD_W'(half_s));

    always_comb
    begin
        geom_b_next.hl_nz = (hl != 10'd0);
        geom_b_next.hl    = hl;
        geom_b_next.hl2   = {hl, 1'b0};
        geom_b_next.sw    = 9'(hl >> 1);
        geom_b_next.hw    = half_s;
        geom_b_next.s0    = gapg_pkg::COORD_W'(geom_a_reg.ax - gapg_pkg::COORD_W'(half_s));
        geom_b_next.s1e   = s1e;
        geom_b_next.s1    = gapg_pkg::COORD_W'(s1e - gapg_pkg::COORD_W'(hl));
    end

    always_ff @(posedge clk)
    begin
        geom_a_reg <= geom_a_next;
        geom_b_reg <= geom_b_next;
    end

endmodule

FILE: rtl/gradient_arrow_pattern_generator.sv
// Top level of the gradient arrow test-pattern generator: pixel pipeline and animation phase.
//
// The block turns one pixel coordinate beat into one 32-bit ARGB pixel beat, one pixel per
// clock sustained while the output is not stalled. The pipeline has seven register stages.
// The depth is set by the 16-bit restoring divider that normalizes the column over the
// frame width: a capture stage feeds four divider stages of four quotient bits each,
// followed by the colour and intensity stage and the channel scaling stage. The arrow tests
// run beside the divider and finish with the head product compare in the colour stage. Each
// stage holds its own valid bit and moves whenever the stage after it is empty or moving, so
// bubbles close up and the input keeps accepting while a finished pixel waits at the output.
// A beat with frame_start set advances the animation phase by phase_step before its own pixel
// is shaded, and the band position comes from a 256-entry sine table indexed by the top phase
// bits. Dimension and phase-step registers are to be written while the pipeline is empty,
// which the block itself does not enforce; their derived geometry is registered in geom_a
// and then geom_b, ahead of the stages that read it. There is no clearing pass after reset.
module gradient_arrow_pattern_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gapg_pkg::COORD_W-1:0]   pixel_x,
    input  logic [gapg_pkg::COORD_W-1:0]   pixel_y,
    input  logic                           frame_start,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    argb_pixel,
    output logic                           in_arrow
);

    localparam int CW = gapg_pkg::COORD_W;
    localparam int FW = gapg_pkg::FRAC_W;
    localparam int NW = gapg_pkg::NX_W;
    localparam int IW = gapg_pkg::SINE_IDX_W;
    localparam int NS = gapg_pkg::NSTAGE;
    localparam int DS = gapg_pkg::DIV_STAGES;

    logic [31:0]        phase_step;
    gapg_pkg::geom_a_t  geom_a;
    gapg_pkg::geom_b_t  geom_b;

    gapg_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .phase_step (phase_step),
        .geom_a_reg (geom_a),
        .geom_b_reg (geom_b)
    );

    // Pipeline control. A stage may load when it is empty or when its content moves on.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic          accept;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_stall = !en[0];
    assign accept   = in_valid && en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Animation phase. The table entry of the phase after this beat's update is the band
    // position, and the reset phase of zero maps to one half, the reset band position.
    logic [31:0] phase_reg;
    logic [31:0] phase_next;

    assign phase_next = (accept && frame_start) ? phase_reg + phase_step : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Stage 1: capture the coordinates and the table index.
    logic [CW-1:0] s1_x_reg, s1_y_reg;
    logic [IW-1:0] s1_idx_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_x_reg   <= pixel_x;
            s1_y_reg   <= pixel_y;
            s1_idx_reg <= phase_next[31 -: IW];
        end
    end

    // Stages 2 to 5: the divider. A column at or past the last one saturates at one, and a
    // frame narrower than two pixels forces the position to zero.
    logic [CW-1:0] div_r [DS+1];
    logic [FW-1:0] div_q [DS+1];

    assign div_r[0] = s1_x_reg;
    assign div_q[0] = '0;

    for (genvar g = 0; g < DS; g++)
    begin : g_div
        gapg_div_stage u_div (
            .clk   (clk),
            .en    (en[g+1]),
            .d     (geom_a.d),
            .r_in  (div_r[g]),
            .q_in  (div_q[g]),
            .r_reg (div_r[g+1]),
            .q_reg (div_q[g+1])
        );
    end

    logic [DS-1:0] sat_reg, narrow_reg;
    logic [CW-1:0] s2_x_reg, s2_y_reg, s3_x_reg, s3_y_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [NW-1:0] s3_band_reg, s4_band_reg, s5_band_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sat_reg[0]    <= (s1_x_reg >= geom_a.d);
            narrow_reg[0] <= geom_a.narrow;
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_idx_reg    <= s1_idx_reg;
        end
        for (int i = 1; i < DS; i++)
        begin
            if (en[i+1])
            begin
                sat_reg[i]    <= sat_reg[i-1];
                narrow_reg[i] <= narrow_reg[i-1];
            end
        end
        if (en[2])
        begin
            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_band_reg <= gapg_pkg::SINE_TAB[s2_idx_reg];
        end
        if (en[3])
        begin
            s4_band_reg <= s3_band_reg;
        end
        if (en[4])
        begin
            s5_band_reg <= s4_band_reg;
        end
    end

    // Arrow, first step (into stage 4): stem test, head column range and the two factors.
    logic [CW-1:0] s4_dy_next, s4_dy_reg;
    logic [9:0]    s4_a_next, s4_a_reg;
    logic          s4_stem_next, s4_stem_reg;
    logic          s4_range_next, s4_range_reg;

    always_comb
    begin
        s4_dy_next    = (s3_y_reg >= geom_a.ay) ? CW'(s3_y_reg - geom_a.ay) :
                        CW'(geom_a.ay - s3_y_reg);
        s4_stem_next  = (s3_x_reg >= geom_b.s0) && (s3_x_reg <= geom_b.s1) &&
                        ({s4_dy_next, 1'b0} <= (CW + 1)'(geom_b.sw));
        s4_range_next = geom_b.hl_nz && (s3_x_reg >= geom_b.s1) &&
                        (s3_x_reg <= geom_b.s1e);
        s4_a_next     = 10'(geom_b.s1e - s3_x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_dy_reg    <= s4_dy_next;
            s4_a_reg     <= s4_a_next;
            s4_stem_reg  <= s4_stem_next;
            s4_range_reg <= s4_range_next;
        end
    end

    // Arrow, second step (into stage 5): both sides of the head taper test.
    logic [22:0] s5_lhs_next, s5_lhs_reg;
    logic [20:0] s5_rhs_next, s5_rhs_reg;
    logic        s5_stem_reg, s5_range_reg;

    assign s5_lhs_next = 23'(geom_b.hl2) * 23'(s4_dy_reg);
    assign s5_rhs_next = 21'(geom_b.hw) * 21'(s4_a_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_lhs_reg   <= s5_lhs_next;
            s5_rhs_reg   <= s5_rhs_next;
            s5_stem_reg  <= s4_stem_reg;
            s5_range_reg <= s4_range_reg;
        end
    end

    // Stage 6: gradient colours, arrow override and the band intensity.
    logic [NW-1:0] nx;
    logic [NW-1:0] inv_nx;
    logic [24:0]   red_prod, blue_prod;
    logic [NW-1:0] band_diff;
    logic [NW:0]   twice;
    logic [NW-1:0] clipped;
    logic [NW-1:0] inten_raw;
    logic          s6_arrow_next, s6_arrow_reg;
    logic [7:0]    s6_red_next, s6_red_reg;
    logic [7:0]    s6_green_next, s6_green_reg;
    logic [7:0]    s6_blue_next, s6_blue_reg;
    logic [NW-1:0] s6_inten_next, s6_inten_reg;

    always_comb
    begin
        if (narrow_reg[DS-1])
        begin
            nx = '0;
        end
        else if (sat_reg[DS-1])
        begin
            nx = gapg_pkg::ONE_Q16;
        end
        else
        begin
            nx = NW'(div_q[DS]);
        end
        inv_nx    = gapg_pkg::ONE_Q16 - nx;
        red_prod  = 25'(inv_nx) * 25'(255);
        blue_prod = 25'(nx) * 25'(255);

        s6_arrow_next = s5_stem_reg || (s5_range_reg && (s5_lhs_reg <= 23'(s5_rhs_reg)));
        if (s6_arrow_next)
        begin
            s6_red_next   = gapg_pkg::CH_FULL;
            s6_green_next = gapg_pkg::CH_FULL;
            s6_blue_next  = gapg_pkg::CH_FULL;
        end
        else
        begin
            s6_red_next   = 8'(red_prod >> FW);
            s6_green_next = 8'd0;
            s6_blue_next  = 8'(blue_prod >> FW);
        end

        band_diff = (nx > s5_band_reg) ? nx - s5_band_reg : s5_band_reg - nx;
        twice     = {band_diff, 1'b0};
        clipped   = (twice > (NW + 1)'(gapg_pkg::ONE_Q16)) ? gapg_pkg::ONE_Q16 : NW'(twice);
        inten_raw = gapg_pkg::ONE_Q16 - clipped;
        s6_inten_next = (inten_raw < gapg_pkg::HALF_Q16) ? gapg_pkg::HALF_Q16 : inten_raw;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_arrow_reg <= s6_arrow_next;
            s6_red_reg   <= s6_red_next;
            s6_green_reg <= s6_green_next;
            s6_blue_reg  <= s6_blue_next;
            s6_inten_reg <= s6_inten_next;
        end
    end

    // Stage 7: dim each channel by the intensity and pack the pixel.
    logic [24:0] red_dim, green_dim, blue_dim;
    logic [31:0] s7_argb_next, s7_argb_reg;
    logic        s7_arrow_reg;

    assign red_dim      = 25'(s6_red_reg) * 25'(s6_inten_reg);
    assign green_dim    = 25'(s6_green_reg) * 25'(s6_inten_reg);
    assign blue_dim     = 25'(s6_blue_reg) * 25'(s6_inten_reg);
    assign s7_argb_next = {gapg_pkg::ALPHA, 8'(red_dim >> FW), 8'(green_dim >> FW),
                           8'(blue_dim >> FW)};

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_argb_reg  <= s7_argb_next;
            s7_arrow_reg <= s6_arrow_reg;
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign argb_pixel = s7_argb_reg;
    assign in_arrow   = s7_arrow_reg;

    // The phase moves only on an accepted beat that starts a frame.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && frame_start) |=> $stable(phase_reg))
        else $error("animation phase changed without an accepted frame start");

    // The input is held off only when every stage is full and the output is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_stall))
        else $error("input stalled while the pipeline has room");

    // Arrow pixels are grey: all three channels carry the same dimmed value.
    a_arrow_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_arrow) |->
        (argb_pixel[23:16] == argb_pixel[15:8] && argb_pixel[15:8] == argb_pixel[7:0]))
        else $error("arrow pixel with unequal channels");

    // Outside the arrow the green channel stays dark.
    a_green_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_arrow) |-> (argb_pixel[15:8] == 8'd0))
        else $error("green set on a gradient pixel");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the gradient arrow pattern generator.
`timescale 1ns / 1ps

module tb;

    // The pipeline has seven stages; the settle pause leaves a little margin on top.
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int COORD_MAX     = 4095;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [gapg_pkg::COORD_W-1:0] pixel_x;
    logic [gapg_pkg::COORD_W-1:0] pixel_y;
    logic        frame_start;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] argb_pixel;
    logic        in_arrow;

    // When set, both the pixel source and the display side insert random gaps.
    bit bursty;
    int cur_w;
    int cur_h;
    int cycle_count;

    // One pixel the block still owes us, kept with its coordinate for the error line.
    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] argb;
        logic        arrow;
    } pixel_t;

    // Scoreboard: carries its own copy of the animation state and the frame registers,
    // shades every accepted coordinate beat and matches output beats in order.
    class pattern_checker;
        localparam longint UNITY       = 65536;
        localparam longint Q30_ONE     = 1073741824;
        localparam longint Q30_HALF_PI = 1686629713;
        localparam int     LUT_DEPTH   = gapg_pkg::SINE_DEPTH;

        logic [12:0] width_reg;
        logic [12:0] height_reg;
        logic [31:0] step_reg;
        logic [31:0] phase_acc;
        logic [16:0] band_pos;
        logic [16:0] band_lut [LUT_DEPTH];
        pixel_t      expected_pixels [$];
        int          error_count;

        function new();
            width_reg   = gapg_pkg::RESET_WIDTH;
            height_reg  = gapg_pkg::RESET_HEIGHT;
            step_reg    = gapg_pkg::RESET_STEP;
            phase_acc   = '0;
            band_pos    = gapg_pkg::HALF_Q16;
            error_count = 0;
            build_band_lut();
        endfunction

        // Taylor series up to the 13th power for an angle in the first quadrant, Q30.
        function longint quarter_sine_q30(longint angle);
            longint sq;
            longint term;
            longint acc;
            sq   = (angle * angle) >> 30;
            term = angle;
            acc  = angle;
            for (int k = 1; k <= 6; k++)
            begin
                term = ((term * sq) >> 30) / ((2 * k) * (2 * k + 1));
                acc  = (k % 2 == 1) ? acc - term : acc + term;
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > Q30_ONE)
            begin
                acc = Q30_ONE;
            end
            return acc;
        endfunction

        // Band position table: (sin + 1) / 2 in Q1.16, built from the first quadrant.
        function void build_band_lut();
            longint quad;
            longint rem;
            longint mirror;
            longint level;
            for (int k = 0; k < LUT_DEPTH; k++)
            begin
                quad   = (4 * k) / LUT_DEPTH;
                rem    = (4 * k) % LUT_DEPTH;
                mirror = quad[0] ? LUT_DEPTH - rem : rem;
                level  = quarter_sine_q30((Q30_HALF_PI * mirror) / LUT_DEPTH);
                level  = (quad < 2) ? Q30_ONE + level : Q30_ONE - level;
                level  = (level + 16384) >> 15;
                if (level > UNITY)
                begin
                    level = UNITY;
                end
                band_lut[k] = level[16:0];
            end
        endfunction

        function void set_reg(gapg_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                gapg_pkg::REG_FRAME_WIDTH:  width_reg  = value[12:0];
                gapg_pkg::REG_FRAME_HEIGHT: height_reg = value[12:0];
                gapg_pkg::REG_PHASE_STEP:   step_reg   = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Shade one accepted coordinate and queue the pixel it must produce.
        function void note_pixel(logic [11:0] x, logic [11:0] y, logic fs);
            longint w, h, px, py, s, ax, ay, sw, hw, hl, s0, s1, dy;
            longint nx, red, green, blue, band_diff, twice, inten;
            logic   arrow;
            pixel_t item;
            if (fs)
            begin
                phase_acc = phase_acc + step_reg;
                band_pos  = band_lut[(longint'(phase_acc) * LUT_DEPTH) >> 32];
            end
            w  = (width_reg > gapg_pkg::MAX_DIM) ? gapg_pkg::MAX_DIM : width_reg;
            h  = (height_reg > gapg_pkg::MAX_DIM) ? gapg_pkg::MAX_DIM : height_reg;
            px = x;
            py = y;

            // Horizontal position in Q1.16; a frame narrower than two columns stays at zero.
            nx = 0;
            if (w >= 2)
            begin
                nx = (px * UNITY) / (w - 1);
                if (nx > UNITY)
                begin
                    nx = UNITY;
                end
            end

            s  = ((w < h) ? w : h) / 2;
            ax = w / 2;
            ay = h / 2;
            sw = s / 6;
            hw = s / 2;
            hl = s / 3;
            s0 = ax - s / 2;
            s1 = ax + s / 2 - hl;
            dy = (py > ay) ? py - ay : ay - py;

            arrow = (px >= s0 && px <= s1 && 2 * py >= 2 * ay - sw && 2 * py <= 2 * ay + sw);
            if (hl > 0 && px >= s1 && px <= s1 + hl && 2 * hl * dy <= hw * (hl - (px - s1)))
            begin
                arrow = 1'b1;
            end

            red   = ((UNITY - nx) * 255) >> 16;
            blue  = (nx * 255) >> 16;
            green = 0;
            if (arrow)
            begin
                red   = 255;
                green = 255;
                blue  = 255;
            end

            band_diff = (nx > band_pos) ? nx - band_pos : band_pos - nx;
            twice     = 2 * band_diff;
            if (twice > UNITY)
            begin
                twice = UNITY;
            end
            inten = UNITY - twice;
            if (inten < UNITY / 2)
            begin
                inten = UNITY / 2;
            end

            red   = (red * inten) >> 16;
            green = (green * inten) >> 16;
            blue  = (blue * inten) >> 16;

            item.x     = x;
            item.y     = y;
            item.argb  = {gapg_pkg::ALPHA, 8'(red), 8'(green), 8'(blue)};
            item.arrow = arrow;
            expected_pixels.push_back(item);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            error_count++;
        endtask

        task check_pixel(logic [31:0] argb, logic arrow);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("pixel %h arrived with nothing outstanding", argb));
                return;
            end
            want = expected_pixels.pop_front();
            if (argb !== want.argb)
            begin
                report($sformatf("argb_pixel at (%0d,%0d): got %h, want %h",
                                 want.x, want.y, argb, want.argb));
            end
            if (arrow !== want.arrow)
            begin
                report($sformatf("in_arrow at (%0d,%0d): got %b, want %b",
                                 want.x, want.y, arrow, want.arrow));
            end
        endtask
    endclass

    pattern_checker sb;

    gradient_arrow_pattern_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .argb_pixel  (argb_pixel),
        .in_arrow    (in_arrow)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [11:0] to_coord(int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > COORD_MAX)
        begin
            return 12'(COORD_MAX);
        end
        return v[11:0];
    endfunction

    // APB write: setup cycle, then the access cycle, completing when pready is seen.
    task automatic write_reg(gapg_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Present one coordinate beat and hold it until the block takes it. The valid line
    // stays high afterwards unless a gap is drawn, so back-to-back beats never drop it.
    task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic fs);
        int gap;
        @(negedge clk);
        in_valid    = 1'b1;
        pixel_x     = x;
        pixel_y     = y;
        frame_start = fs;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_pixel(x, y, fs);
        gap = bursty ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending, wait for every owed pixel, then let the pipeline run dry.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers change only with the pipeline empty.
    task automatic apply_setting(int w, int h, logic [31:0] step);
        settle();
        write_reg(gapg_pkg::REG_FRAME_WIDTH, 32'(w));
        write_reg(gapg_pkg::REG_FRAME_HEIGHT, 32'(h));
        write_reg(gapg_pkg::REG_PHASE_STEP, step);
        cur_w = w;
        cur_h = h;
    endtask

    // Coordinates are drawn around the arrow, inside the frame, on the frame edges or
    // anywhere in the 12-bit range, so both shape tests and saturation get exercised.
    task automatic send_random_pixel(logic fs);
        int ew, eh, s, mode, xv, yv;
        ew   = (cur_w > gapg_pkg::MAX_DIM) ? gapg_pkg::MAX_DIM : cur_w;
        eh   = (cur_h > gapg_pkg::MAX_DIM) ? gapg_pkg::MAX_DIM : cur_h;
        mode = $urandom_range(0, 99);
        if (mode < 30)
        begin
            s  = ((ew < eh) ? ew : eh) / 2;
            xv = $urandom_range(to_coord(ew / 2 - s / 2 - 2), to_coord(ew / 2 + s / 2 + 2));
            yv = $urandom_range(to_coord(eh / 2 - s / 4 - 2), to_coord(eh / 2 + s / 4 + 2));
        end
        else if (mode < 60)
        begin
            xv = $urandom_range(0, to_coord(ew - 1));
            yv = $urandom_range(0, to_coord(eh - 1));
        end
        else if (mode < 75)
        begin
            case ($urandom_range(0, 3))
                0: xv = 0;
                1: xv = ew - 1;
                2: xv = ew;
                default: xv = COORD_MAX;
            endcase
            case ($urandom_range(0, 3))
                0: yv = 0;
                1: yv = eh - 1;
                2: yv = eh;
                default: yv = COORD_MAX;
            endcase
        end
        else
        begin
            xv = $urandom_range(0, COORD_MAX);
            yv = $urandom_range(0, COORD_MAX);
        end
        send_pixel(to_coord(xv), to_coord(yv), fs);
    endtask

    // Display side: random back-pressure whenever bursty traffic is on.
    initial
    begin
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                hold--;
            end
            else
            begin
                out_stall = 1'b0;
                if (bursty)
                begin
                    hold = pick_gap();
                end
            end
        end
    end

    // Every output beat taken by the display side is checked against the oldest pixel owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_pixel(argb_pixel, in_arrow);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int   p;
        int   n;
        int   frame_left;
        logic fs;

        sb          = new();
        bursty      = 1'b0;
        cur_w       = gapg_pkg::RESET_WIDTH;
        cur_h       = gapg_pkg::RESET_HEIGHT;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        pixel_x     = '0;
        pixel_y     = '0;
        frame_start = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry is 640 x 480: the stem spans columns 200 to 360 and lines 220 to
        // 260, the head runs from column 360 to its tip at column 440 on line 240.
        send_pixel(12'd0, 12'd0, 1'b0);       // left edge, red end of the gradient
        send_pixel(12'd639, 12'd479, 1'b0);   // last column and line
        send_pixel(12'd640, 12'd0, 1'b0);     // one past the last column saturates
        send_pixel(12'd4095, 12'd4095, 1'b0); // all coordinate bits set
        send_pixel(12'd200, 12'd220, 1'b0);   // stem corner
        send_pixel(12'd199, 12'd240, 1'b0);   // just left of the stem
        send_pixel(12'd200, 12'd219, 1'b0);   // just above the stem
        send_pixel(12'd360, 12'd300, 1'b1);   // head edge, first frame start
        send_pixel(12'd360, 12'd301, 1'b1);   // repeated frame start, just outside the head
        send_pixel(12'd440, 12'd240, 1'b0);   // arrow tip
        send_pixel(12'd441, 12'd240, 1'b0);   // one past the tip
        send_pixel(12'd320, 12'd240, 1'b0);   // frame center

        // Single-column frame: no horizontal gradient and no head.
        apply_setting(1, 3, gapg_pkg::RESET_STEP);
        send_pixel(12'd0, 12'd1, 1'b0);
        send_pixel(12'd4095, 12'd0, 1'b0);
        send_pixel(12'd0, 12'd0, 1'b1);

        // 5 x 5 frame: a one-line stem from column 1 to 3, head length zero.
        apply_setting(5, 5, 32'h8000_0000);
        send_pixel(12'd1, 12'd2, 1'b1);
        send_pixel(12'd3, 12'd2, 1'b0);
        send_pixel(12'd4, 12'd2, 1'b0);

        // Both dimensions above the maximum clamp to it; largest phase step.
        apply_setting(8191, 8191, 32'hFFFF_FFFF);
        send_pixel(12'd4095, 12'd2048, 1'b1);
        send_pixel(12'd2048, 12'd2048, 1'b1);
        send_pixel(12'd0, 12'd4095, 1'b0);

        // Random frames under a spread of settings, the register extremes among them.
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_setting(2, gapg_pkg::MAX_DIM, 32'h0000_0000);
                1: apply_setting(gapg_pkg::MAX_DIM, 1, 32'hFFFF_FFFF);
                2: apply_setting(8191, 8191, $urandom);
                3: apply_setting(0, 0, $urandom);
                4: apply_setting(gapg_pkg::RESET_WIDTH, gapg_pkg::RESET_HEIGHT,
                                 gapg_pkg::RESET_STEP);
                5: apply_setting($urandom_range(2, gapg_pkg::MAX_DIM),
                                 $urandom_range(1, gapg_pkg::MAX_DIM), $urandom);
                default: apply_setting($urandom_range(2, 200), $urandom_range(1, 200),
                                       $urandom);
            endcase
            frame_left = 0;
            for (n = 0; n < 55; n++)
            begin
                // Alternate stretches with and without gaps on both sides.
                if (n % 20 == 0)
                begin
                    bursty = ($urandom_range(0, 3) != 0);
                end
                // Each frame opens with a frame start beat; a few stray ones repeat it.
                if (frame_left == 0)
                begin
                    fs         = 1'b1;
                    frame_left = $urandom_range(3, 30);
                end
                else
                begin
                    fs = ($urandom_range(0, 19) == 0);
                    frame_left--;
                end
                send_random_pixel(fs);
            end
        end

        settle();
        if (sb.error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/gapg_pkg.sv
rtl/gapg_div_stage.sv
rtl/gapg_cfg.sv
rtl/gradient_arrow_pattern_generator.sv
bench/tb.sv
